@@ src/sawarq_pkg.sv @@
`default_nettype none

package sawarq_pkg;

  // fsm states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TX   = 2'd1;
  localparam logic [1:0] ST_ACK  = 2'd2;

  // commands
  localparam logic CMD_POST = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // event kinds, also bit positions in the pending flags
  localparam logic [2:0] EV_REQ   = 3'd0;
  localparam logic [2:0] EV_RX    = 3'd1;
  localparam logic [2:0] EV_ACKRX = 3'd2;
  localparam logic [2:0] EV_DTXD  = 3'd3;
  localparam logic [2:0] EV_ATXD  = 3'd4;
  localparam logic [2:0] EV_TMO   = 3'd5;
  localparam int         NUM_EV   = 6;

  // actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_DELIVER = 3'd3;
  localparam logic [2:0] ACT_CONFIRM = 3'd4;
  localparam logic [2:0] ACT_TSTART  = 3'd5;
  localparam logic [2:0] ACT_TSTOP   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_RETX = 2'd0;
  localparam logic [1:0] CFG_SEQ_MOD  = 2'd1;
  localparam logic [1:0] CFG_HDR      = 2'd2;

  // configuration reset values
  localparam logic [7:0] MAX_RETX_RST = 8'd3;
  localparam logic [8:0] SEQ_MOD_RST  = 9'd8;
  localparam logic [7:0] HDR_RST      = 8'd3;

  // parameter defaults
  localparam int AGG_BUFFER_BYTES_DEF = 1024;
  localparam int BROADCAST_ADDR_DEF   = 255;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  peer;
    logic [7:0]  seq;
    logic [10:0] length;
    logic        flag;
    logic [1:0]  state;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ src/stop_and_wait_arq_controller_core.sv @@
`default_nettype none

// channel  | ports                                             | direction
// ---------+---------------------------------------------------+----------
// in       | in_valid/in_ready, cmd, event_kind, peer_id, ...  | beat in
// out      | out_valid/out_ready, action, peer_out, ... last   | beat out
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data          | write in
//
// a post beat leaves no result
// a step beat is worked out in the cycle it is taken; its one or two results go into a
// two-slot result register, and the next beat waits until the last of them is taken
// in_ready is high while the result register is empty or its last result leaves this cycle
// synchronous active-low reset returns the fsm to idle and restores the register defaults
// cfg_ready is always high

module stop_and_wait_arq_controller_core #(
  parameter int AGG_BUFFER_BYTES = sawarq_pkg::AGG_BUFFER_BYTES_DEF,
  parameter int BROADCAST_ADDR   = sawarq_pkg::BROADCAST_ADDR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [2:0]  in_event_kind,
  input  wire logic [7:0]  in_peer_id,
  input  wire logic [7:0]  in_seq_in,
  input  wire logic [7:0]  in_length_in,
  input  wire logic        in_broadcast_in,
  input  wire logic        in_end_in,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_action,
  output logic [7:0]       out_peer_out,
  output logic [7:0]       out_seq_out,
  output logic [10:0]      out_length_out,
  output logic             out_flag_out,
  output logic [1:0]       out_state_out,
  output logic             out_last_out,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  // aggregate saturates at the buffer size, never above what 11 bits hold
  localparam logic [10:0] AGG_CAP = 11'((AGG_BUFFER_BYTES > 2047) ? 2047 : AGG_BUFFER_BYTES);
  localparam logic [7:0]  BC_ADDR = 8'(BROADCAST_ADDR);

  // configuration
  logic [7:0] max_retx_r;
  logic [8:0] seq_mod_r;
  logic [7:0] hdr_r;

  // protocol state
  logic [1:0]                      state_r, state_nxt;
  logic [sawarq_pkg::NUM_EV-1:0]   pend_r, pend_nxt;
  logic [7:0]                      seq_r, seq_nxt;
  logic [7:0]                      retry_r, retry_nxt;
  logic                            timer_r, timer_nxt;
  logic [7:0]                      req_dest_r, req_dest_nxt;
  logic [7:0]                      req_len_r, req_len_nxt;
  logic                            req_end_r, req_end_nxt;
  logic [7:0]                      sent_seq_r, sent_seq_nxt;
  logic [7:0]                      sent_len_r, sent_len_nxt;
  logic                            sent_end_r, sent_end_nxt;
  logic [7:0]                      sent_dest_r, sent_dest_nxt;
  logic [7:0]                      rx_src_r, rx_src_nxt;
  logic [7:0]                      rx_seq_r, rx_seq_nxt;
  logic [7:0]                      rx_size_r, rx_size_nxt;
  logic                            rx_bc_r, rx_bc_nxt;
  logic                            rx_end_r, rx_end_nxt;
  logic [7:0]                      ack_seq_r, ack_seq_nxt;
  logic [10:0]                     agg_r, agg_nxt;

  // result register: two slots and a fill count
  sawarq_pkg::res_t slot0_r, slot1_r;
  logic [1:0]       cnt_r;

  // handshakes
  logic in_fire, out_fire, step_fire, post_fire;

  // step results
  sawarq_pkg::res_t r0, r1;
  logic [1:0]       nres;

  // received-frame arithmetic, shared by idle and wait-ack
  logic        rx_match, rx_take, rx_deliver;
  logic [7:0]  rx_pay;
  logic [11:0] rx_sum;
  logic [10:0] rx_agg_sat;
  logic        do_rx;

  // sequence counter increment with wrap
  logic [8:0]  seq_inc;
  logic [7:0]  seq_next_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign step_fire = in_fire && (in_cmd == sawarq_pkg::CMD_STEP);
  assign post_fire = in_fire && (in_cmd == sawarq_pkg::CMD_POST);

  assign out_action     = slot0_r.action;
  assign out_peer_out   = slot0_r.peer;
  assign out_seq_out    = slot0_r.seq;
  assign out_length_out = slot0_r.length;
  assign out_flag_out   = slot0_r.flag;
  assign out_state_out  = slot0_r.state;
  assign out_last_out   = slot0_r.last;

  // counter wraps to zero at the modulus; modulus above 256 wraps at 256 through the truncation
  assign seq_inc      = {1'b0, seq_r} + 9'd1;
  assign seq_next_val = (seq_inc >= seq_mod_r) ? 8'd0 : seq_inc[7:0];

  assign rx_match   = (rx_seq_r == seq_r);
  assign rx_take    = rx_bc_r || rx_match;
  assign rx_deliver = rx_take && (rx_bc_r || rx_end_r);
  assign rx_pay     = (rx_size_r > hdr_r) ? (rx_size_r - hdr_r) : 8'd0;
  assign rx_sum     = {1'b0, agg_r} + {4'b0000, rx_pay};
  assign rx_agg_sat = (rx_sum > {1'b0, AGG_CAP}) ? AGG_CAP : rx_sum[10:0];

  // frame reception wins in idle; in wait-ack only after ack rx and timeout
  assign do_rx = (state_r == sawarq_pkg::ST_IDLE && pend_r[sawarq_pkg::EV_RX]) ||
                 (state_r == sawarq_pkg::ST_ACK && !pend_r[sawarq_pkg::EV_ACKRX] &&
                  !pend_r[sawarq_pkg::EV_TMO] && pend_r[sawarq_pkg::EV_RX]);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    seq_nxt       = seq_r;
    retry_nxt     = retry_r;
    timer_nxt     = timer_r;
    req_dest_nxt  = req_dest_r;
    req_len_nxt   = req_len_r;
    req_end_nxt   = req_end_r;
    sent_seq_nxt  = sent_seq_r;
    sent_len_nxt  = sent_len_r;
    sent_end_nxt  = sent_end_r;
    sent_dest_nxt = sent_dest_r;
    rx_src_nxt    = rx_src_r;
    rx_seq_nxt    = rx_seq_r;
    rx_size_nxt   = rx_size_r;
    rx_bc_nxt     = rx_bc_r;
    rx_end_nxt    = rx_end_r;
    ack_seq_nxt   = ack_seq_r;
    agg_nxt       = agg_r;
    r0            = '0;
    r1            = '0;
    nres          = 2'd1;

    if (post_fire) begin
      // latch the event and its operands; unknown kinds are dropped
      case (in_event_kind)
        sawarq_pkg::EV_REQ: begin
          req_dest_nxt = in_peer_id;
          req_len_nxt  = in_length_in;
          req_end_nxt  = in_end_in;
        end
        sawarq_pkg::EV_RX: begin
          rx_src_nxt  = in_peer_id;
          rx_seq_nxt  = in_seq_in;
          rx_size_nxt = in_length_in;
          rx_bc_nxt   = in_broadcast_in;
          rx_end_nxt  = in_end_in;
        end
        sawarq_pkg::EV_ACKRX: ack_seq_nxt = in_seq_in;
        sawarq_pkg::EV_TMO:   timer_nxt   = 1'b0;
        default: ;
      endcase
      if (in_event_kind < 3'(sawarq_pkg::NUM_EV)) begin
        pend_nxt[in_event_kind] = 1'b1;
      end
    end else if (step_fire) begin
      if (do_rx) begin
        if (rx_take) begin
          agg_nxt = rx_deliver ? 11'd0 : rx_agg_sat;
        end
        if (rx_deliver) begin
          r0.action = sawarq_pkg::ACT_DELIVER;
          r0.peer   = rx_src_r;
          r0.length = rx_agg_sat;
          if (!rx_bc_r) begin
            r1.action = sawarq_pkg::ACT_ACK;
            r1.peer   = rx_src_r;
            r1.seq    = rx_seq_r;
            nres      = 2'd2;
          end
        end else begin
          r0.action = sawarq_pkg::ACT_ACK;
          r0.peer   = rx_src_r;
          r0.seq    = rx_seq_r;
        end
        if (rx_bc_r) begin
          state_nxt = sawarq_pkg::ST_IDLE;
        end else begin
          state_nxt = sawarq_pkg::ST_TX;
          if (rx_match) seq_nxt = seq_next_val;
        end
        pend_nxt[sawarq_pkg::EV_RX] = 1'b0;
      end else begin
        unique case (state_r)
          sawarq_pkg::ST_IDLE: begin
            if (pend_r[sawarq_pkg::EV_REQ]) begin
              sent_seq_nxt  = seq_r;
              sent_len_nxt  = req_len_r;
              sent_end_nxt  = req_end_r;
              sent_dest_nxt = req_dest_r;
              r0.action = sawarq_pkg::ACT_SEND;
              r0.peer   = req_dest_r;
              r0.seq    = seq_r;
              r0.length = {3'b000, req_len_r};
              r0.flag   = req_end_r;
              if (req_dest_r != BC_ADDR) seq_nxt = seq_next_val;
              retry_nxt = 8'd0;
              state_nxt = sawarq_pkg::ST_TX;
              pend_nxt[sawarq_pkg::EV_REQ] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_DTXD]) begin
              pend_nxt[sawarq_pkg::EV_DTXD] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_ATXD]) begin
              pend_nxt[sawarq_pkg::EV_ATXD] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_ACKRX]) begin
              pend_nxt[sawarq_pkg::EV_ACKRX] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_TMO]) begin
              pend_nxt[sawarq_pkg::EV_TMO] = 1'b0;
            end
          end
          sawarq_pkg::ST_TX: begin
            if (pend_r[sawarq_pkg::EV_ATXD]) begin
              state_nxt = (timer_r || pend_r[sawarq_pkg::EV_TMO]) ?
                          sawarq_pkg::ST_ACK : sawarq_pkg::ST_IDLE;
              pend_nxt[sawarq_pkg::EV_ATXD] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_DTXD]) begin
              if (sent_dest_r == BC_ADDR) begin
                state_nxt = sawarq_pkg::ST_IDLE;
                r0.action = sawarq_pkg::ACT_CONFIRM;
                r0.flag   = 1'b1;
              end else begin
                state_nxt = sawarq_pkg::ST_ACK;
                timer_nxt = 1'b1;
                r0.action = sawarq_pkg::ACT_TSTART;
              end
              pend_nxt[sawarq_pkg::EV_DTXD] = 1'b0;
            end
          end
          sawarq_pkg::ST_ACK: begin
            if (pend_r[sawarq_pkg::EV_ACKRX]) begin
              if (sent_seq_r == ack_seq_r) begin
                timer_nxt = 1'b0;
                state_nxt = sawarq_pkg::ST_IDLE;
                r0.action = sawarq_pkg::ACT_TSTOP;
                r1.action = sawarq_pkg::ACT_CONFIRM;
                r1.flag   = 1'b1;
                nres      = 2'd2;
              end
              pend_nxt[sawarq_pkg::EV_ACKRX] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_TMO]) begin
              if (retry_r >= max_retx_r) begin
                state_nxt = sawarq_pkg::ST_IDLE;
                r0.action = sawarq_pkg::ACT_CONFIRM;
              end else begin
                r0.action = sawarq_pkg::ACT_SEND;
                r0.peer   = sent_dest_r;
                r0.seq    = sent_seq_r;
                r0.length = {3'b000, sent_len_r};
                r0.flag   = sent_end_r;
                retry_nxt = retry_r + 8'd1;
                state_nxt = sawarq_pkg::ST_TX;
              end
              pend_nxt[sawarq_pkg::EV_TMO] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_DTXD]) begin
              pend_nxt[sawarq_pkg::EV_DTXD] = 1'b0;
            end else if (pend_r[sawarq_pkg::EV_ATXD]) begin
              pend_nxt[sawarq_pkg::EV_ATXD] = 1'b0;
            end
          end
          default: ;  // unused state code: nothing happens
        endcase
      end
    end

    // every result of the step reports the state after the step
    r0.state = state_nxt;
    r1.state = state_nxt;
    r0.last  = (nres == 2'd1);
    r1.last  = 1'b1;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retx_r <= sawarq_pkg::MAX_RETX_RST;
      seq_mod_r  <= sawarq_pkg::SEQ_MOD_RST;
      hdr_r      <= sawarq_pkg::HDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sawarq_pkg::CFG_MAX_RETX: max_retx_r <= cfg_data[7:0];
        sawarq_pkg::CFG_SEQ_MOD:  seq_mod_r  <= cfg_data;
        sawarq_pkg::CFG_HDR:      hdr_r      <= cfg_data[7:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sawarq_pkg::ST_IDLE;
      pend_r      <= '0;
      seq_r       <= '0;
      retry_r     <= '0;
      timer_r     <= 1'b0;
      req_dest_r  <= '0;
      req_len_r   <= '0;
      req_end_r   <= 1'b0;
      sent_seq_r  <= '0;
      sent_len_r  <= '0;
      sent_end_r  <= 1'b0;
      sent_dest_r <= '0;
      rx_src_r    <= '0;
      rx_seq_r    <= '0;
      rx_size_r   <= '0;
      rx_bc_r     <= 1'b0;
      rx_end_r    <= 1'b0;
      ack_seq_r   <= '0;
      agg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      seq_r       <= seq_nxt;
      retry_r     <= retry_nxt;
      timer_r     <= timer_nxt;
      req_dest_r  <= req_dest_nxt;
      req_len_r   <= req_len_nxt;
      req_end_r   <= req_end_nxt;
      sent_seq_r  <= sent_seq_nxt;
      sent_len_r  <= sent_len_nxt;
      sent_end_r  <= sent_end_nxt;
      sent_dest_r <= sent_dest_nxt;
      rx_src_r    <= rx_src_nxt;
      rx_seq_r    <= rx_seq_nxt;
      rx_size_r   <= rx_size_nxt;
      rx_bc_r     <= rx_bc_nxt;
      rx_end_r    <= rx_end_nxt;
      ack_seq_r   <= ack_seq_nxt;
      agg_r       <= agg_nxt;
    end
  end

  // result slots: a step loads both, a taken beat moves the second forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (step_fire) begin
      cnt_r <= nres;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      slot0_r <= r0;
      slot1_r <= r1;
    end else if (out_fire) begin
      slot0_r <= slot1_r;
    end
  end

  // the result register never holds more than two beats
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  // with two results waiting, only the second carries the last mark
  a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last))
    else $error("last mark on wrong slot");

  // every step leaves at least one result to be taken
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> out_valid)
    else $error("step left no result");

  // a step that goes to send data in idle moves to tx
  a_send_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && !do_rx && state_r == sawarq_pkg::ST_IDLE && pend_r[sawarq_pkg::EV_REQ])
      |=> (state_r == sawarq_pkg::ST_TX))
    else $error("request did not enter tx");

endmodule

`default_nettype wire

@@ bench/arq_bench_pkg.sv @@
package arq_bench_pkg;

  import sawarq_pkg::*;

  localparam int AGG_CAP = (AGG_BUFFER_BYTES_DEF > 2047) ? 2047 : AGG_BUFFER_BYTES_DEF;

  // link controller predictor plus the queue of actions it expects
  class arq_scoreboard;

    logic [7:0]  max_retx;
    logic [8:0]  seq_mod;
    logic [7:0]  hdr_len;

    logic [1:0]  fsm;
    logic [5:0]  pend;
    logic [7:0]  seq_cnt;
    logic [7:0]  retry_cnt;
    logic        timer_on;
    logic [7:0]  req_dest, req_len;
    logic        req_eom;
    logic [7:0]  sent_seq, sent_len, sent_dest;
    logic        sent_eom;
    logic [7:0]  rx_src, rx_seq, rx_size;
    logic        rx_bc, rx_eom;
    logic [7:0]  ack_seq;
    logic [10:0] rx_agg;

    res_t        exp_actions[$];
    res_t        step_buf[$];
    int          errors;
    int          checked;
    int          shown;

    function new();
      errors  = 0;
      checked = 0;
      shown   = 0;
      restore();
    endfunction

    function void restore();
      max_retx  = MAX_RETX_RST;
      seq_mod   = SEQ_MOD_RST;
      hdr_len   = HDR_RST;
      fsm       = ST_IDLE;
      pend      = '0;
      seq_cnt   = '0;
      retry_cnt = '0;
      timer_on  = 1'b0;
      req_dest  = '0;
      req_len   = '0;
      req_eom   = 1'b0;
      sent_seq  = '0;
      sent_len  = '0;
      sent_dest = '0;
      sent_eom  = 1'b0;
      rx_src    = '0;
      rx_seq    = '0;
      rx_size   = '0;
      rx_bc     = 1'b0;
      rx_eom    = 1'b0;
      ack_seq   = '0;
      rx_agg    = '0;
      exp_actions.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        CFG_MAX_RETX: max_retx = data[7:0];
        CFG_SEQ_MOD:  seq_mod  = data;
        CFG_HDR:      hdr_len  = data[7:0];
        default: ;
      endcase
    endfunction

    function int waiting();
      return exp_actions.size();
    endfunction

    function logic [7:0] next_seq(logic [7:0] s);
      int unsigned n;
      n = s + 1;
      if (n >= seq_mod) n = 0;
      return n[7:0];
    endfunction

    function void emit(logic [2:0] act, logic [7:0] peer, logic [7:0] seq,
                       logic [10:0] len, logic flag);
      res_t r;
      if (step_buf.size() >= 2) return;
      r.action = act;
      r.peer   = peer;
      r.seq    = seq;
      r.length = len;
      r.flag   = flag;
      r.state  = ST_IDLE;
      r.last   = 1'b0;
      step_buf.push_back(r);
    endfunction

    function void take_frame();
      int unsigned pay;
      int unsigned sum;
      logic        match;
      match = (rx_seq == seq_cnt);
      if (rx_bc || match) begin
        pay = (rx_size > hdr_len) ? rx_size - hdr_len : 0;
        sum = rx_agg + pay;
        rx_agg = (sum > AGG_CAP) ? 11'(AGG_CAP) : 11'(sum);
        if (rx_bc || rx_eom) begin
          emit(ACT_DELIVER, rx_src, 8'd0, rx_agg, 1'b0);
          rx_agg = '0;
        end
      end
      if (rx_bc) begin
        fsm = ST_IDLE;
      end else begin
        if (match) seq_cnt = next_seq(seq_cnt);
        emit(ACT_ACK, rx_src, rx_seq, 11'd0, 1'b0);
        fsm = ST_TX;
      end
      pend[EV_RX] = 1'b0;
    endfunction

    function void send_data();
      emit(ACT_SEND, sent_dest, sent_seq, {3'b000, sent_len}, sent_eom);
    endfunction

    function void step_idle();
      if (pend[EV_RX]) begin
        take_frame();
      end else if (pend[EV_REQ]) begin
        sent_seq  = seq_cnt;
        sent_len  = req_len;
        sent_eom  = req_eom;
        sent_dest = req_dest;
        send_data();
        if (req_dest != BROADCAST_ADDR_DEF) seq_cnt = next_seq(seq_cnt);
        retry_cnt = '0;
        fsm = ST_TX;
        pend[EV_REQ] = 1'b0;
      end else if (pend[EV_DTXD]) begin
        pend[EV_DTXD] = 1'b0;
      end else if (pend[EV_ATXD]) begin
        pend[EV_ATXD] = 1'b0;
      end else if (pend[EV_ACKRX]) begin
        pend[EV_ACKRX] = 1'b0;
      end else if (pend[EV_TMO]) begin
        pend[EV_TMO] = 1'b0;
      end
    endfunction

    function void step_tx();
      if (pend[EV_ATXD]) begin
        fsm = (timer_on || pend[EV_TMO]) ? ST_ACK : ST_IDLE;
        pend[EV_ATXD] = 1'b0;
      end else if (pend[EV_DTXD]) begin
        if (sent_dest == BROADCAST_ADDR_DEF) begin
          fsm = ST_IDLE;
          emit(ACT_CONFIRM, 8'd0, 8'd0, 11'd0, 1'b1);
        end else begin
          fsm = ST_ACK;
          timer_on = 1'b1;
          emit(ACT_TSTART, 8'd0, 8'd0, 11'd0, 1'b0);
        end
        pend[EV_DTXD] = 1'b0;
      end
    endfunction

    function void step_ack();
      if (pend[EV_ACKRX]) begin
        if (sent_seq == ack_seq) begin
          timer_on = 1'b0;
          fsm = ST_IDLE;
          emit(ACT_TSTOP, 8'd0, 8'd0, 11'd0, 1'b0);
          emit(ACT_CONFIRM, 8'd0, 8'd0, 11'd0, 1'b1);
        end
        pend[EV_ACKRX] = 1'b0;
      end else if (pend[EV_TMO]) begin
        if (retry_cnt >= max_retx) begin
          fsm = ST_IDLE;
          emit(ACT_CONFIRM, 8'd0, 8'd0, 11'd0, 1'b0);
        end else begin
          send_data();
          retry_cnt = retry_cnt + 8'd1;
          fsm = ST_TX;
        end
        pend[EV_TMO] = 1'b0;
      end else if (pend[EV_RX]) begin
        take_frame();
      end else if (pend[EV_DTXD]) begin
        pend[EV_DTXD] = 1'b0;
      end else if (pend[EV_ATXD]) begin
        pend[EV_ATXD] = 1'b0;
      end
    endfunction

    // one accepted input beat: a post latches, a step predicts its actions
    function void note_beat(logic cmd, logic [2:0] ev, logic [7:0] peer, logic [7:0] seq,
                            logic [7:0] len, logic bc, logic eom);
      res_t r;
      if (cmd == CMD_POST) begin
        if (ev > EV_TMO) return;
        case (ev)
          EV_REQ: begin
            req_dest = peer;
            req_len  = len;
            req_eom  = eom;
          end
          EV_RX: begin
            rx_src  = peer;
            rx_seq  = seq;
            rx_size = len;
            rx_bc   = bc;
            rx_eom  = eom;
          end
          EV_ACKRX: ack_seq  = seq;
          EV_TMO:   timer_on = 1'b0;
          default: ;
        endcase
        pend[ev] = 1'b1;
        return;
      end
      step_buf.delete();
      case (fsm)
        ST_IDLE: step_idle();
        ST_TX:   step_tx();
        ST_ACK:  step_ack();
        default: ;
      endcase
      if (step_buf.size() == 0) emit(ACT_NONE, 8'd0, 8'd0, 11'd0, 1'b0);
      foreach (step_buf[k]) begin
        r = step_buf[k];
        r.state = fsm;
        r.last  = (k == step_buf.size() - 1);
        exp_actions.push_back(r);
      end
    endfunction

    function void check_action(res_t got);
      res_t want;
      if (exp_actions.size() == 0) begin
        errors++;
        if (shown < 10)
          $display("unexpected action beat: act=%0d peer=%0d seq=%0d len=%0d flag=%0d st=%0d last=%0d",
                   got.action, got.peer, got.seq, got.length, got.flag, got.state, got.last);
        shown++;
        return;
      end
      want = exp_actions.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          $display("action mismatch at check %0d", checked);
          $display("  expected act=%0d peer=%0d seq=%0d len=%0d flag=%0d st=%0d last=%0d",
                   want.action, want.peer, want.seq, want.length, want.flag, want.state,
                   want.last);
          $display("  actual   act=%0d peer=%0d seq=%0d len=%0d flag=%0d st=%0d last=%0d",
                   got.action, got.peer, got.seq, got.length, got.flag, got.state, got.last);
        end
        shown++;
      end
    endfunction

  endclass

endpackage

@@ bench/tb_stop_and_wait_arq_controller_core.sv @@
module tb_stop_and_wait_arq_controller_core;

  timeunit 1ns;
  timeprecision 1ps;

  import sawarq_pkg::*;
  import arq_bench_pkg::*;

  localparam int NUM_PHASES = 8;
  localparam int PHASE_BEATS = 190;

  logic        clk;
  logic        rst_n;

  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [2:0]  in_event_kind;
  logic [7:0]  in_peer_id;
  logic [7:0]  in_seq_in;
  logic [7:0]  in_length_in;
  logic        in_broadcast_in;
  logic        in_end_in;

  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_action;
  logic [7:0]  out_peer_out;
  logic [7:0]  out_seq_out;
  logic [10:0] out_length_out;
  logic        out_flag_out;
  logic [1:0]  out_state_out;
  logic        out_last_out;

  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  arq_scoreboard sb;

  // when set, neither side inserts idle cycles
  logic        calm = 1'b0;
  int          beats_sent = 0;

  // register settings per phase; the random phases are filled in at run time
  int unsigned ph_retx[NUM_PHASES] = '{0, 255, 1, 2, 5, 0, 0, 3};
  int unsigned ph_mod[NUM_PHASES]  = '{2, 256, 0, 1, 511, 0, 0, 8};
  int unsigned ph_hdr[NUM_PHASES]  = '{0, 255, 8, 3, 0, 0, 0, 3};

  stop_and_wait_arq_controller_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_event_kind   (in_event_kind),
    .in_peer_id      (in_peer_id),
    .in_seq_in       (in_seq_in),
    .in_length_in    (in_length_in),
    .in_broadcast_in (in_broadcast_in),
    .in_end_in       (in_end_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_peer_out    (out_peer_out),
    .out_seq_out     (out_seq_out),
    .out_length_out  (out_length_out),
    .out_flag_out    (out_flag_out),
    .out_state_out   (out_state_out),
    .out_last_out    (out_last_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the handshakes hang
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // frame sizes lean long so the receive aggregate reaches its cap now and then
  function automatic logic [7:0] frame_len();
    return $urandom_range(0, 1) ? 8'($urandom_range(200, 255)) : rnd8();
  endfunction

  // result side: ready stalls at random, outputs sampled mid-cycle when settled,
  // and a beat counts as taken at the following rising edge
  initial begin
    res_t seen;
    logic took;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      took        = rst_n && out_valid && out_ready;
      seen.action = out_action;
      seen.peer   = out_peer_out;
      seen.seq    = out_seq_out;
      seen.length = out_length_out;
      seen.flag   = out_flag_out;
      seen.state  = out_state_out;
      seen.last   = out_last_out;
      @(posedge clk);
      if (took) sb.check_action(seen);
      out_ready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // one input beat; valid is raised only after any idle cycles and then held
  task automatic send_beat(logic cmd, logic [2:0] ev, logic [7:0] peer, logic [7:0] seq,
                           logic [7:0] len, logic bc, logic eom);
    logic acc;
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_event_kind   <= ev;
    in_peer_id      <= peer;
    in_seq_in       <= seq;
    in_length_in    <= len;
    in_broadcast_in <= bc;
    in_end_in       <= eom;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    sb.note_beat(cmd, ev, peer, seq, len, bc, eom);
    // posts of unused event kinds are ignored by the block, so not counted
    if (!(cmd == CMD_POST && ev > EV_TMO)) beats_sent++;
  endtask

  task automatic post(logic [2:0] ev, logic [7:0] peer, logic [7:0] seq, logic [7:0] len,
                      logic bc, logic eom);
    send_beat(CMD_POST, ev, peer, seq, len, bc, eom);
  endtask

  // a step beat carries junk in the unused fields
  task automatic step();
    send_beat(CMD_STEP, 3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rbit(), rbit());
  endtask

  // stop sending until every predicted action has come back, then let the
  // block settle after any trailing post beat
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // three register writes back to back; valid lowered once at the end
  task automatic set_regs(int unsigned retx, int unsigned modv, int unsigned hdr);
    logic       acc;
    logic [1:0] idx[3];
    logic [8:0] val[3];
    idx[0] = CFG_MAX_RETX;
    idx[1] = CFG_SEQ_MOD;
    idx[2] = CFG_HDR;
    val[0] = 9'(retx);
    val[1] = 9'(modv);
    val[2] = 9'(hdr);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do begin
        @(negedge clk);
        acc = cfg_ready;
        @(posedge clk);
      end while (!acc);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // received frame, mostly carrying the sequence the receiver expects
  task automatic post_frame();
    logic [7:0] src;
    logic [7:0] seq;
    src = ($urandom_range(0, 9) == 0) ? 8'(BROADCAST_ADDR_DEF) : rnd8();
    seq = ($urandom_range(0, 99) < 80) ? sb.seq_cnt : rnd8();
    post(EV_RX, src, seq, frame_len(), ($urandom_range(0, 99) < 15),
         ($urandom_range(0, 99) < 20));
  endtask

  // post an event that makes sense for the current state of the link
  task automatic post_for_state();
    int unsigned coin;
    logic [7:0]  dest;
    logic [7:0]  seq;
    coin = $urandom_range(0, 99);
    case (sb.fsm)
      ST_IDLE: begin
        if (coin < 55) begin
          dest = ($urandom_range(0, 6) == 0) ? 8'(BROADCAST_ADDR_DEF) : rnd8();
          post(EV_REQ, dest, rnd8(), rnd8(), rbit(), rbit());
        end else begin
          post_frame();
        end
      end
      ST_TX: begin
        if (coin < 45) post(EV_DTXD, rnd8(), rnd8(), rnd8(), rbit(), rbit());
        else if (coin < 90) post(EV_ATXD, rnd8(), rnd8(), rnd8(), rbit(), rbit());
        else post_frame();
      end
      ST_ACK: begin
        if (coin < 55) begin
          seq = ($urandom_range(0, 99) < 85) ? sb.sent_seq : rnd8();
          post(EV_ACKRX, rnd8(), seq, rnd8(), rbit(), rbit());
        end else if (coin < 85) begin
          post(EV_TMO, rnd8(), rnd8(), rnd8(), rbit(), rbit());
        end else begin
          post_frame();
        end
      end
      default: post(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rbit(), rbit());
    endcase
  endtask

  // mostly post/step pairs that follow the protocol, the rest is noise
  task automatic run_random(int count);
    int start;
    start = beats_sent;
    while (beats_sent - start < count) begin
      if ($urandom_range(0, 199) == 0) drain();
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 3) == 0) step();
        else post(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rbit(), rbit());
      end else begin
        post_for_state();
        step();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_POST;
    in_event_kind   <= EV_REQ;
    in_peer_id      <= '0;
    in_seq_in       <= '0;
    in_length_in    <= '0;
    in_broadcast_in <= 1'b0;
    in_end_in       <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_MAX_RETX;
    cfg_data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass with the reset register values
    // step with nothing pending gives no action
    step();
    // unused event kinds are dropped
    post(3'd6, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    post(3'd7, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // unicast send, one timeout and retransmit, then a matching ack
    post(EV_REQ, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1);
    step();
    post(EV_DTXD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    post(EV_TMO, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    post(EV_DTXD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    post(EV_ACKRX, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    // short frame in sequence: acked but adds nothing
    post(EV_RX, 8'd7, 8'd1, 8'd2, 1'b0, 1'b0);
    step();
    post(EV_ATXD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    // full-size last frame: delivered then acked
    post(EV_RX, 8'd9, 8'd2, 8'hFF, 1'b0, 1'b1);
    step();
    post(EV_ATXD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    // broadcast send confirms straight after tx done
    post(EV_REQ, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    post(EV_DTXD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    step();
    // broadcast frame is delivered and never acked
    post(EV_RX, 8'hFF, 8'h00, 8'd1, 1'b1, 1'b0);
    step();
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 5 || p == 6) begin
        ph_retx[p] = $urandom_range(0, 255);
        ph_mod[p]  = $urandom_range(2, 256);
        ph_hdr[p]  = $urandom_range(0, 40);
      end
      // long stretch with no idling on either side
      calm = (p == 2);
      set_regs(ph_retx[p], ph_mod[p], ph_hdr[p]);
      run_random(PHASE_BEATS);
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (sb.waiting() != 0) sb.errors++;

    $display("run covered %0d input beats over %0d register settings", beats_sent,
             NUM_PHASES + 1);
    $display("%0d action beats checked, %0d failures", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
